@@ design/e2g_pkg.sv @@
package e2g_pkg;

    localparam int DW               = 64;
    localparam int FRAC_BITS_DEF    = 48;
    localparam int CORDIC_STEPS_DEF = 48;
    localparam int DIST_FRAC        = 24;
    localparam int MUL_LAT          = 4;

    typedef logic signed [DW-1:0] word_t;

    // pole bypass: flag, sign of z, finished height
    typedef struct packed {
        logic              pole;
        logic              neg;
        logic signed [34:0] h;
    } pole_t;

    localparam logic [63:0] PI4_Q62    = 64'h3243F6A8885A308D;
    localparam logic [63:0] INVK_Q62   = 64'd2800459870029452953;
    localparam logic [63:0] E2_Q62     = 64'd30872378602574698;
    localparam word_t       AOVERB_Q62 = 64'sd4627200144419518615;
    localparam word_t       A_MM       = 64'sd6378137000;
    localparam word_t       POLE_B_MM  = 64'sd6356752314;
    localparam word_t       A_Q24      = A_MM * 64'sd16777216;
    localparam word_t       E2A_Q24    = 64'sd42697672 * 64'sd16777216 + 64'sd11864538;
    localparam word_t       EP2B_Q24   = 64'sd42841311 * 64'sd16777216 + 64'sd8611914;
    localparam word_t       RAD2E7_Q30 = 64'sd572957795 * 64'sd1073741824 + 64'sd140470520;
    localparam word_t       HALF_MM    = 64'sd1 <<< (DIST_FRAC - 1);

    localparam word_t LAT_MAX = 64'sd900000000;
    localparam word_t LAT_MIN = -64'sd900000000;
    localparam word_t LON_MAX = 64'sd1800000000;
    localparam word_t LON_MIN = -64'sd1800000000;
    localparam word_t H_MAX   = 64'sd10000000000;
    localparam word_t H_MIN   = -64'sd10000000000;

    // restoring division, used only on constants
    function automatic logic [63:0] udiv(input logic [63:0] n, input logic [63:0] d);
        logic [64:0] r;
        logic [63:0] q;
        r = '0;
        q = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[63:0], n[b]};
            if (r >= {1'b0, d}) begin
                r    = r - {1'b0, d};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [63:0] q62_to_f(input logic [63:0] c, input int f);
        return (c + (64'd1 << (61 - f))) >> (62 - f);
    endfunction

    // atan(2^-i) in Q62 from the truncated series
    function automatic logic [63:0] atan_q62(input int i);
        logic [63:0] t;
        int          e;
        t = '0;
        e = 0;
        if (i == 0) begin
            t = PI4_Q62;
        end
        else begin
            for (int k = 0; k < 32; k++) begin
                e = 62 - i * (2 * k + 1);
                if (e >= 0) begin
                    if ((k & 1) != 0)
                        t = t - udiv(64'd1 << e, 64'(2 * k + 1));
                    else
                        t = t + udiv(64'd1 << e, 64'(2 * k + 1));
                end
            end
        end
        return t;
    endfunction

    function automatic logic [63:0] atan_f(input int i, input int f);
        return q62_to_f(atan_q62(i), f);
    endfunction

endpackage

@@ design/ecef_to_geodetic.sv @@
// Channel   Dir  Handshake            Payload
// request   in   req_valid/req_ready  x_mm, y_mm, z_mm
// result    out  rsp_valid/rsp_ready  lat_e7deg, lon_e7deg, height_mm, at_pole
//
// One request accepted per cycle while no result waits in the skid register; each
// passes through the five chained CORDIC pipelines, the multipliers and the root pipeline.
// Reset clears only the valid bits and the output/skid flags.
// A stalled result parks in a skid register; the pipeline then freezes as a whole
// and req_ready drops until the skid register drains.
module ecef_to_geodetic
    import e2g_pkg::*;
#(
    parameter int FRAC_BITS    = FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  logic signed [34:0] x_mm,
    input  logic signed [34:0] y_mm,
    input  logic signed [34:0] z_mm,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output logic signed [30:0] lat_e7deg,
    output logic signed [31:0] lon_e7deg,
    output logic signed [34:0] height_mm,
    output logic               at_pole
);

    localparam int C = CORDIC_STEPS;
    localparam int F = FRAC_BITS;
    localparam int M = MUL_LAT;

    localparam int T_A = C;
    localparam int T_B = T_A + M;
    localparam int T_C = T_B + C;
    localparam int T_D = T_C + C;
    localparam int T_E = T_D + 3 * M;
    localparam int T_F = T_E + 1;
    localparam int T_G = T_F + C;
    localparam int T_H = T_G + C;
    localparam int T_W = T_H + 2 * M + 1;
    localparam int T_I = T_W + F + 1;
    localparam int T_J = T_I + M;
    localparam int T_K = T_J + 1;
    localparam int T_L = T_K + 1;

    localparam word_t ONE     = 64'sd1 <<< F;
    localparam word_t HALF_PI = word_t'(2 * q62_to_f(PI4_Q62, F));
    localparam word_t INVK_F  = word_t'(q62_to_f(INVK_Q62, F));
    localparam word_t E2_F    = word_t'(q62_to_f(E2_Q62, F));

    logic en;
    logic [T_L:0] v_reg;

    // input stage
    word_t z0_reg, cx0_reg, cy0_reg, lon0_reg;
    pole_t pole0_reg;
    word_t xs, ys, zs, cx0_next, cy0_next, lon0_next, az, ph;
    pole_t pole0_next;

    always_comb
    begin
        xs = word_t'(x_mm) <<< DIST_FRAC;
        ys = word_t'(y_mm) <<< DIST_FRAC;
        zs = word_t'(z_mm) <<< DIST_FRAC;
        if (xs < 0)
        begin
            if (ys >= 0)
            begin
                cx0_next  = ys;
                cy0_next  = -xs;
                lon0_next = HALF_PI;
            end
            else
            begin
                cx0_next  = -ys;
                cy0_next  = xs;
                lon0_next = -HALF_PI;
            end
        end
        else
        begin
            cx0_next  = xs;
            cy0_next  = ys;
            lon0_next = '0;
        end
        az = z_mm[34] ? -word_t'(z_mm) : word_t'(z_mm);
        ph = az - POLE_B_MM;
        if (ph > H_MAX)
            ph = H_MAX;
        pole0_next.pole = (x_mm == '0) && (y_mm == '0);
        pole0_next.neg  = z_mm[34];
        pole0_next.h    = ph[34:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            z0_reg    <= zs;
            cx0_reg   <= cx0_next;
            cy0_reg   <= cy0_next;
            lon0_reg  <= lon0_next;
            pole0_reg <= pole0_next;
        end
    end

    // longitude and horizontal distance
    word_t lon_cx, lon_z, p_b, zs_m, zs_b;

    e2g_cordic #(.STEPS(C), .FRAC(F), .VEC(1'b1)) u_lon_cordic (
        .clk(clk), .en(en), .x_in(cx0_reg), .y_in(cy0_reg), .z_in(lon0_reg),
        .x_out(lon_cx), .y_out(), .z_out(lon_z));

    e2g_mul #(.SHIFT(62)) u_p_mul (
        .clk(clk), .en(en), .a(lon_cx), .b(word_t'(INVK_Q62)), .p(p_b));

    e2g_mul #(.SHIFT(62)) u_zs_mul (
        .clk(clk), .en(en), .a(z0_reg), .b(AOVERB_Q62), .p(zs_m));

    e2g_dly #(.W(DW), .D(C)) u_zs_dly (.clk(clk), .en(en), .din(zs_m), .dout(zs_b));

    // parametric latitude
    word_t th_c, ct_d, st_d;

    e2g_cordic #(.STEPS(C), .FRAC(F), .VEC(1'b1)) u_th_cordic (
        .clk(clk), .en(en), .x_in(p_b), .y_in(zs_b), .z_in('0),
        .x_out(), .y_out(), .z_out(th_c));

    e2g_cordic #(.STEPS(C), .FRAC(F), .VEC(1'b0)) u_th_rot (
        .clk(clk), .en(en), .x_in(INVK_F), .y_in('0), .z_in(th_c),
        .x_out(ct_d), .y_out(st_d), .z_out());

    word_t ct_dd, st_dd, c2, s2, c3, s3, m_den, m_num;

    e2g_dly #(.W(DW), .D(M)) u_ct_dly (.clk(clk), .en(en), .din(ct_d), .dout(ct_dd));
    e2g_dly #(.W(DW), .D(M)) u_st_dly (.clk(clk), .en(en), .din(st_d), .dout(st_dd));

    e2g_mul #(.SHIFT(F)) u_c2_mul (.clk(clk), .en(en), .a(ct_d), .b(ct_d), .p(c2));
    e2g_mul #(.SHIFT(F)) u_s2_mul (.clk(clk), .en(en), .a(st_d), .b(st_d), .p(s2));
    e2g_mul #(.SHIFT(F)) u_c3_mul (.clk(clk), .en(en), .a(c2), .b(ct_dd), .p(c3));
    e2g_mul #(.SHIFT(F)) u_s3_mul (.clk(clk), .en(en), .a(s2), .b(st_dd), .p(s3));
    e2g_mul #(.SHIFT(F)) u_den_mul (.clk(clk), .en(en), .a(E2A_Q24), .b(c3), .p(m_den));
    e2g_mul #(.SHIFT(F)) u_num_mul (.clk(clk), .en(en), .a(EP2B_Q24), .b(s3), .p(m_num));

    word_t z_e, p_e;

    e2g_dly #(.W(DW), .D(T_E)) u_z_e_dly (.clk(clk), .en(en), .din(z0_reg), .dout(z_e));
    e2g_dly #(.W(DW), .D(T_E - T_B)) u_p_e_dly (.clk(clk), .en(en), .din(p_b), .dout(p_e));

    // geodetic latitude
    word_t num_reg, den_reg;
    logic  zero_reg;
    word_t num_next, den_next;

    always_comb
    begin
        num_next = z_e + m_num;
        den_next = p_e - m_den;
        if (den_next < 0)
        begin
            den_next = -den_next;
            num_next = -num_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg  <= num_next;
            den_reg  <= den_next;
            zero_reg <= (num_next == '0) && (den_next == '0);
        end
    end

    word_t lat_raw, lat_m;
    logic  zero_g;

    e2g_cordic #(.STEPS(C), .FRAC(F), .VEC(1'b1)) u_lat_cordic (
        .clk(clk), .en(en), .x_in(den_reg), .y_in(num_reg), .z_in('0),
        .x_out(), .y_out(), .z_out(lat_raw));

    e2g_dly #(.W(1), .D(T_G - T_F)) u_zero_dly (
        .clk(clk), .en(en), .din(zero_reg), .dout(zero_g));

    assign lat_m = zero_g ? '0 : lat_raw;

    // height
    word_t cl_h, sl_h, z_h, p_h;

    e2g_cordic #(.STEPS(C), .FRAC(F), .VEC(1'b0)) u_lat_rot (
        .clk(clk), .en(en), .x_in(INVK_F), .y_in('0), .z_in(lat_m),
        .x_out(cl_h), .y_out(sl_h), .z_out());

    e2g_dly #(.W(DW), .D(T_H - T_E)) u_z_h_dly (.clk(clk), .en(en), .din(z_e), .dout(z_h));
    e2g_dly #(.W(DW), .D(T_H - T_E)) u_p_h_dly (.clk(clk), .en(en), .din(p_e), .dout(p_h));

    word_t sl2, e2t, pcl, zsl, pcl_j, zsl_j, asq;
    logic [F:0] ww_reg;
    logic [F:0] sq;
    word_t ww;

    e2g_mul #(.SHIFT(F)) u_sl2_mul (.clk(clk), .en(en), .a(sl_h), .b(sl_h), .p(sl2));
    e2g_mul #(.SHIFT(F)) u_e2_mul (.clk(clk), .en(en), .a(E2_F), .b(sl2), .p(e2t));

    always_comb
    begin
        ww = ONE - e2t;
        if (ww < 0)
            ww = '0;
        else if (ww > ONE)
            ww = ONE;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            ww_reg <= ww[F:0];
    end

    e2g_sqrt #(.FRAC(F)) u_sqrt (.clk(clk), .en(en), .w(ww_reg), .root(sq));

    e2g_mul #(.SHIFT(F)) u_asq_mul (
        .clk(clk), .en(en), .a(A_Q24), .b({{(63 - F){1'b0}}, sq}), .p(asq));

    e2g_mul #(.SHIFT(F)) u_pcl_mul (.clk(clk), .en(en), .a(p_h), .b(cl_h), .p(pcl));
    e2g_mul #(.SHIFT(F)) u_zsl_mul (.clk(clk), .en(en), .a(z_h), .b(sl_h), .p(zsl));

    e2g_dly #(.W(DW), .D(T_J - T_H - M)) u_pcl_dly (
        .clk(clk), .en(en), .din(pcl), .dout(pcl_j));
    e2g_dly #(.W(DW), .D(T_J - T_H - M)) u_zsl_dly (
        .clk(clk), .en(en), .din(zsl), .dout(zsl_j));

    word_t h_reg;

    always_ff @(posedge clk)
    begin
        if (en)
            h_reg <= pcl_j + zsl_j - asq;
    end

    // angle scaling
    word_t lat_e7, lon_e7, lat_k, lon_k;
    pole_t pole_k;

    e2g_mul #(.SHIFT(F + 30)) u_lat_e7_mul (
        .clk(clk), .en(en), .a(lat_m), .b(RAD2E7_Q30), .p(lat_e7));
    e2g_mul #(.SHIFT(F + 30)) u_lon_e7_mul (
        .clk(clk), .en(en), .a(lon_z), .b(RAD2E7_Q30), .p(lon_e7));

    e2g_dly #(.W(DW), .D(T_K - T_G - M)) u_lat_dly (
        .clk(clk), .en(en), .din(lat_e7), .dout(lat_k));
    e2g_dly #(.W(DW), .D(T_K - T_A - M)) u_lon_dly (
        .clk(clk), .en(en), .din(lon_e7), .dout(lon_k));
    e2g_dly #(.W($bits(pole_t)), .D(T_K)) u_pole_dly (
        .clk(clk), .en(en), .din(pole0_reg), .dout(pole_k));

    // final stage: clamp and pole override
    logic signed [30:0] lat_f_reg, lat_f_next;
    logic signed [31:0] lon_f_reg, lon_f_next;
    logic signed [34:0] h_f_reg, h_f_next;
    logic               pole_f_reg;
    word_t lat_c, lon_c, hr;

    always_comb
    begin
        lat_c = (lat_k > LAT_MAX) ? LAT_MAX : ((lat_k < LAT_MIN) ? LAT_MIN : lat_k);
        lon_c = (lon_k > LON_MAX) ? LON_MAX : ((lon_k < LON_MIN) ? LON_MIN : lon_k);
        hr    = (h_reg + HALF_MM) >>> DIST_FRAC;
        hr    = (hr > H_MAX) ? H_MAX : ((hr < H_MIN) ? H_MIN : hr);
        if (pole_k.pole)
        begin
            lat_f_next = pole_k.neg ? LAT_MIN[30:0] : LAT_MAX[30:0];
            lon_f_next = '0;
            h_f_next   = pole_k.h;
        end
        else
        begin
            lat_f_next = lat_c[30:0];
            lon_f_next = lon_c[31:0];
            h_f_next   = hr[34:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lat_f_reg  <= lat_f_next;
            lon_f_reg  <= lon_f_next;
            h_f_reg    <= h_f_next;
            pole_f_reg <= pole_k.pole;
        end
    end

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[T_L-1:0], req_valid};
    end

    // output register and skid register
    logic               out_v_reg, out_v_next, skid_v_reg, skid_v_next;
    logic signed [30:0] lat_o_reg, lat_o_next, lat_s_reg, lat_s_next;
    logic signed [31:0] lon_o_reg, lon_o_next, lon_s_reg, lon_s_next;
    logic signed [34:0] h_o_reg, h_o_next, h_s_reg, h_s_next;
    logic               pole_o_reg, pole_o_next, pole_s_reg, pole_s_next;

    assign en = !skid_v_reg;

    always_comb
    begin
        out_v_next  = out_v_reg;
        skid_v_next = skid_v_reg;
        lat_o_next  = lat_o_reg;
        lon_o_next  = lon_o_reg;
        h_o_next    = h_o_reg;
        pole_o_next = pole_o_reg;
        lat_s_next  = lat_s_reg;
        lon_s_next  = lon_s_reg;
        h_s_next    = h_s_reg;
        pole_s_next = pole_s_reg;
        if (skid_v_reg)
        begin
            if (rsp_ready)
            begin
                lat_o_next  = lat_s_reg;
                lon_o_next  = lon_s_reg;
                h_o_next    = h_s_reg;
                pole_o_next = pole_s_reg;
                skid_v_next = 1'b0;
            end
        end
        else if (v_reg[T_L])
        begin
            if (out_v_reg && !rsp_ready)
            begin
                lat_s_next  = lat_f_reg;
                lon_s_next  = lon_f_reg;
                h_s_next    = h_f_reg;
                pole_s_next = pole_f_reg;
                skid_v_next = 1'b1;
            end
            else
            begin
                lat_o_next  = lat_f_reg;
                lon_o_next  = lon_f_reg;
                h_o_next    = h_f_reg;
                pole_o_next = pole_f_reg;
                out_v_next  = 1'b1;
            end
        end
        else if (rsp_ready)
        begin
            out_v_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else
        begin
            out_v_reg  <= out_v_next;
            skid_v_reg <= skid_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lat_o_reg  <= lat_o_next;
        lon_o_reg  <= lon_o_next;
        h_o_reg    <= h_o_next;
        pole_o_reg <= pole_o_next;
        lat_s_reg  <= lat_s_next;
        lon_s_reg  <= lon_s_next;
        h_s_reg    <= h_s_next;
        pole_s_reg <= pole_s_next;
    end

    assign req_ready = en;
    assign rsp_valid = out_v_reg;
    assign lat_e7deg = lat_o_reg;
    assign lon_e7deg = lon_o_reg;
    assign height_mm = h_o_reg;
    assign at_pole   = pole_o_reg;

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_v_reg |-> out_v_reg)
        else $error("skid register holds a result while the output is empty");

    a_pole_angles: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && at_pole) |-> (lon_e7deg == 32'sd0 &&
        (lat_e7deg == 31'sd900000000 || lat_e7deg == -31'sd900000000)))
        else $error("pole result with wrong angles");

    a_lat_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (lat_e7deg <= 31'sd900000000 && lat_e7deg >= -31'sd900000000))
        else $error("latitude out of range");

endmodule

@@ design/e2g_dly.sv @@
module e2g_dly
    import e2g_pkg::*;
#(
    parameter int W = 64,
    parameter int D = 1
)
(
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);

    logic [W-1:0] d_reg [0:D-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg[0] <= din;
            for (int j = 1; j < D; j++)
            begin
                d_reg[j] <= d_reg[j-1];
            end
        end
    end

    assign dout = d_reg[D-1];

endmodule

@@ design/e2g_mul.sv @@
module e2g_mul
    import e2g_pkg::*;
#(
    parameter int SHIFT = 62
)
(
    input  logic  clk,
    input  logic  en,
    input  word_t a,
    input  word_t b,
    output word_t p
);

    localparam logic [127:0] RND = 128'd1 << (SHIFT - 1);

    logic         neg_reg, neg2_reg, neg3_reg;
    logic [63:0]  ua_reg, ub_reg;
    logic [63:0]  p00_reg, p01_reg, p10_reg, p11_reg;
    logic [127:0] sum_reg;
    word_t        p_reg;

    logic [127:0] sum_next;
    logic [127:0] q;
    logic [63:0]  mag;
    word_t        p_next;

    always_comb
    begin
        sum_next = {p11_reg, 64'd0} + {32'd0, p01_reg, 32'd0} + {32'd0, p10_reg, 32'd0}
                 + {64'd0, p00_reg} + RND;
        q        = sum_reg >> SHIFT;
        mag      = (|q[127:63]) ? 64'h7FFF_FFFF_FFFF_FFFF : q[63:0];
        p_next   = neg3_reg ? -$signed(mag) : $signed(mag);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_reg  <= a[63] ^ b[63];
            ua_reg   <= a[63] ? 64'd0 - a : a;
            ub_reg   <= b[63] ? 64'd0 - b : b;
            neg2_reg <= neg_reg;
            p00_reg  <= ua_reg[31:0] * ub_reg[31:0];
            p01_reg  <= ua_reg[31:0] * ub_reg[63:32];
            p10_reg  <= ua_reg[63:32] * ub_reg[31:0];
            p11_reg  <= ua_reg[63:32] * ub_reg[63:32];
            neg3_reg <= neg2_reg;
            sum_reg  <= sum_next;
            p_reg    <= p_next;
        end
    end

    assign p = p_reg;

endmodule

@@ design/e2g_cordic.sv @@
module e2g_cordic
    import e2g_pkg::*;
#(
    parameter int STEPS = CORDIC_STEPS_DEF,
    parameter int FRAC  = FRAC_BITS_DEF,
    parameter bit VEC   = 1'b1
)
(
    input  logic  clk,
    input  logic  en,
    input  word_t x_in,
    input  word_t y_in,
    input  word_t z_in,
    output word_t x_out,
    output word_t y_out,
    output word_t z_out
);

    word_t x_reg [0:STEPS-1];
    word_t y_reg [0:STEPS-1];
    word_t z_reg [0:STEPS-1];

    for (genvar i = 0; i < STEPS; i++)
    begin : g_stage
        localparam word_t ANG = word_t'(atan_f(i, FRAC));
        word_t xi, yi, zi, dx, dy, x_next, y_next, z_next;
        logic  up;

        if (i == 0)
        begin : g_first
            assign xi = x_in;
            assign yi = y_in;
            assign zi = z_in;
        end
        else
        begin : g_rest
            assign xi = x_reg[i-1];
            assign yi = y_reg[i-1];
            assign zi = z_reg[i-1];
        end

        always_comb
        begin
            dx = yi >>> i;
            dy = xi >>> i;
            up = VEC ? yi[63] : !zi[63];
            if (up)
            begin
                x_next = xi - dx;
                y_next = yi + dy;
                z_next = zi - ANG;
            end
            else
            begin
                x_next = xi + dx;
                y_next = yi - dy;
                z_next = zi + ANG;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[i] <= x_next;
                y_reg[i] <= y_next;
                z_reg[i] <= z_next;
            end
        end
    end

    assign x_out = x_reg[STEPS-1];
    assign y_out = y_reg[STEPS-1];
    assign z_out = z_reg[STEPS-1];

endmodule

@@ design/e2g_sqrt.sv @@
module e2g_sqrt
    import e2g_pkg::*;
#(
    parameter int FRAC = FRAC_BITS_DEF
)
(
    input  logic          clk,
    input  logic          en,
    input  logic [FRAC:0] w,
    output logic [FRAC:0] root
);

    // floor(sqrt(w * 2^FRAC)), one result bit per stage
    localparam int NW = 2 * FRAC + 2;
    localparam int RW = FRAC + 4;
    localparam int QW = FRAC + 1;

    logic [RW-1:0] rem_reg  [0:QW-1];
    logic [QW-1:0] root_reg [0:QW-1];
    logic [NW-1:0] rad_reg  [0:QW-1];

    for (genvar s = 0; s < QW; s++)
    begin : g_stage
        logic [RW-1:0] rem_i, cat, trial, rem_next;
        logic [QW-1:0] root_i, root_next;
        logic [NW-1:0] rad_i, rad_next;
        logic          ge;

        if (s == 0)
        begin : g_first
            assign rem_i  = '0;
            assign root_i = '0;
            assign rad_i  = {1'b0, w, {FRAC{1'b0}}};
        end
        else
        begin : g_rest
            assign rem_i  = rem_reg[s-1];
            assign root_i = root_reg[s-1];
            assign rad_i  = rad_reg[s-1];
        end

        always_comb
        begin
            cat       = {rem_i[RW-3:0], rad_i[NW-1 -: 2]};
            trial     = {1'b0, root_i, 2'b01};
            ge        = (cat >= trial);
            rem_next  = ge ? cat - trial : cat;
            root_next = {root_i[QW-2:0], ge};
            rad_next  = {rad_i[NW-3:0], 2'b00};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s]  <= rem_next;
                root_reg[s] <= root_next;
                rad_reg[s]  <= rad_next;
            end
        end
    end

    assign root = root_reg[QW-1];

endmodule

@@ tb/sv/ecef_to_geodetic_tb.sv @@
module ecef_to_geodetic_tb;

    localparam int    FRAC       = 48;
    localparam int    STEPS      = 48;
    localparam int    DFRAC      = 24;
    localparam int    LATENCY    = 5 * STEPS + FRAC + 34;
    localparam int    CYCLE_CAP  = 400000;
    localparam longint PI4_Q62    = 64'sh3243F6A8885A308D;
    localparam longint INVK_Q62   = 64'sd2800459870029452953;
    localparam longint E2_Q62     = 64'sd30872378602574698;
    localparam longint AOVERB_Q62 = 64'sd4627200144419518615;
    localparam longint A_MM       = 64'sd6378137000;
    localparam longint POLE_B_MM  = 64'sd6356752314;
    localparam longint E2A_Q24    = 64'sd42697672 * 64'sd16777216 + 64'sd11864538;
    localparam longint EP2B_Q24   = 64'sd42841311 * 64'sd16777216 + 64'sd8611914;
    localparam longint RAD2E7_Q30 = 64'sd572957795 * 64'sd1073741824 + 64'sd140470520;
    localparam longint LAT_LIM    = 64'sd900000000;
    localparam longint LON_LIM    = 64'sd1800000000;
    localparam longint H_LIM      = 64'sd10000000000;

    typedef struct packed {
        logic [30:0] lat;
        logic [31:0] lon;
        logic [34:0] h;
        logic        pole;
    } geo_t;

    class geo_scoreboard;
        geo_t   pending_q[$];
        longint atan_tab[STEPS];
        int     errors;

        function new();
            logic [63:0] t;
            int          e;
            errors = 0;
            for (int i = 0; i < STEPS; i++)
            begin
                t = 0;
                if (i == 0)
                    t = PI4_Q62;
                else
                    for (int k = 0; k < 64; k++)
                    begin
                        e = 62 - i * (2 * k + 1);
                        if (e >= 0)
                        begin
                            if (k & 1)
                                t = t - (64'd1 << e) / 64'(2 * k + 1);
                            else
                                t = t + (64'd1 << e) / 64'(2 * k + 1);
                        end
                    end
                atan_tab[i] = to_frac(t);
            end
        endfunction

        function longint to_frac(logic [63:0] c);
            return $signed((c + (64'd1 << (61 - FRAC))) >> (62 - FRAC));
        endfunction

        // round(a*b / 2^sh) half away from zero, saturated to 64 bits
        function longint scale_round(longint a, longint b, int sh);
            logic         neg;
            logic [63:0]  ua, ub;
            logic [127:0] p;
            neg = (a < 0) != (b < 0);
            ua = a;
            ub = b;
            if (a < 0) ua = 64'd0 - ua;
            if (b < 0) ub = 64'd0 - ub;
            p = {64'd0, ua} * {64'd0, ub};
            if (sh > 0) p = p + (128'd1 << (sh - 1));
            p = p >> sh;
            if (p > 128'h7FFF_FFFF_FFFF_FFFF) p = 128'h7FFF_FFFF_FFFF_FFFF;
            return neg ? -$signed(p[63:0]) : $signed(p[63:0]);
        endfunction

        function void rotate(inout longint x, inout longint y, inout longint z, input bit vec);
            longint dx, dy;
            bit     up;
            for (int i = 0; i < STEPS; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                up = vec ? (y < 0) : (z >= 0);
                if (up)
                begin
                    x = x - dx; y = y + dy; z = z - atan_tab[i];
                end
                else
                begin
                    x = x + dx; y = y - dy; z = z + atan_tab[i];
                end
            end
        endfunction

        function longint root_frac(logic [63:0] w);
            logic [127:0] n;
            logic [63:0]  r, c;
            n = {64'd0, w} << FRAC;
            r = 0;
            for (int b = 61; b >= 0; b--)
            begin
                c = r | (64'd1 << b);
                if ({64'd0, c} * {64'd0, c} <= n) r = c;
            end
            return $signed(r);
        endfunction

        function longint clamp(longint v, longint lim);
            return v < -lim ? -lim : (v > lim ? lim : v);
        endfunction

        function geo_t convert(longint x, longint y, longint z);
            geo_t   r;
            longint one, half_pi, xs, ys, zs, cx, cy, lon, p, zr, th, ct, st, c3, s3;
            longint num, den, lat, cl, sl, ww, sq, h, hmm, az;
            one = 64'sd1 <<< FRAC;
            if (x == 0 && y == 0)
            begin
                az = z < 0 ? -z : z;
                r.lat  = 31'(z < 0 ? -LAT_LIM : LAT_LIM);
                r.lon  = '0;
                r.h    = 35'(clamp(az - POLE_B_MM, H_LIM));
                r.pole = 1'b1;
                return r;
            end
            half_pi = 2 * to_frac(PI4_Q62);
            xs = x <<< DFRAC; ys = y <<< DFRAC; zs = z <<< DFRAC;
            if (xs < 0)
            begin
                if (ys >= 0)
                begin
                    cx = ys; cy = -xs; lon = half_pi;
                end
                else
                begin
                    cx = -ys; cy = xs; lon = -half_pi;
                end
            end
            else
            begin
                cx = xs; cy = ys; lon = 0;
            end
            rotate(cx, cy, lon, 1);
            p = scale_round(cx, INVK_Q62, 62);
            zr = scale_round(zs, AOVERB_Q62, 62);
            cx = p; cy = zr; th = 0;
            rotate(cx, cy, th, 1);
            ct = to_frac(INVK_Q62); st = 0;
            rotate(ct, st, th, 0);
            c3 = scale_round(scale_round(ct, ct, FRAC), ct, FRAC);
            s3 = scale_round(scale_round(st, st, FRAC), st, FRAC);
            num = zs + scale_round(EP2B_Q24, s3, FRAC);
            den = p - scale_round(E2A_Q24, c3, FRAC);
            if (den < 0)
            begin
                den = -den; num = -num;
            end
            lat = 0;
            if (den != 0 || num != 0) rotate(den, num, lat, 1);
            cl = to_frac(INVK_Q62); sl = 0; th = lat;
            rotate(cl, sl, th, 0);
            ww = one - scale_round(to_frac(E2_Q62), scale_round(sl, sl, FRAC), FRAC);
            ww = ww < 0 ? 0 : (ww > one ? one : ww);
            sq = root_frac(ww);
            h = scale_round(p, cl, FRAC) + scale_round(zs, sl, FRAC)
                - scale_round(A_MM <<< DFRAC, sq, FRAC);
            hmm = (h + (64'sd1 <<< (DFRAC - 1))) >>> DFRAC;
            r.lat  = 31'(clamp(scale_round(lat, RAD2E7_Q30, FRAC + 30), LAT_LIM));
            r.lon  = 32'(clamp(scale_round(lon, RAD2E7_Q30, FRAC + 30), LON_LIM));
            r.h    = 35'(clamp(hmm, H_LIM));
            r.pole = 1'b0;
            return r;
        endfunction

        function void note_request(longint x, longint y, longint z);
            pending_q.push_back(convert(x, y, z));
        endfunction

        function void check_result(geo_t got);
            geo_t want;
            if (pending_q.size() == 0)
            begin
                $display("%0t: unexpected result lat=%0d lon=%0d h=%0d pole=%0b", $time,
                         $signed(got.lat), $signed(got.lon), $signed(got.h), got.pole);
                errors++;
                return;
            end
            want = pending_q.pop_front();
            if (got.lat !== want.lat)
            begin
                $display("%0t: lat_e7deg expected %0d actual %0d", $time,
                         $signed(want.lat), $signed(got.lat));
                errors++;
            end
            if (got.lon !== want.lon)
            begin
                $display("%0t: lon_e7deg expected %0d actual %0d", $time,
                         $signed(want.lon), $signed(got.lon));
                errors++;
            end
            if (got.h !== want.h)
            begin
                $display("%0t: height_mm expected %0d actual %0d", $time,
                         $signed(want.h), $signed(got.h));
                errors++;
            end
            if (got.pole !== want.pole)
            begin
                $display("%0t: at_pole expected %0b actual %0b", $time, want.pole, got.pole);
                errors++;
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               req_valid = 1'b0;
    logic               req_ready;
    logic signed [34:0] x_mm = '0;
    logic signed [34:0] y_mm = '0;
    logic signed [34:0] z_mm = '0;
    logic               rsp_valid;
    logic               rsp_ready = 1'b0;
    logic signed [30:0] lat_e7deg;
    logic signed [31:0] lon_e7deg;
    logic signed [34:0] height_mm;
    logic               at_pole;

    geo_scoreboard sb = new();
    int            send_idle_pct = 0;
    int            recv_idle_pct = 0;
    int            cycles = 0;

    ecef_to_geodetic i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .x_mm      (x_mm),
        .y_mm      (y_mm),
        .z_mm      (z_mm),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .lat_e7deg (lat_e7deg),
        .lon_e7deg (lon_e7deg),
        .height_mm (height_mm),
        .at_pole   (at_pole)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("FAIL ecef_to_geodetic");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
            rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        if (rst_n && req_valid && req_ready)
            sb.note_request(x_mm, y_mm, z_mm);
        if (rst_n && rsp_valid && rsp_ready)
            sb.check_result({lat_e7deg, lon_e7deg, height_mm, at_pole});
    end

    task automatic send(longint x, longint y, longint z);
        bit ok;
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        req_valid <= 1'b1;
        x_mm <= 35'(x);
        y_mm <= 35'(y);
        z_mm <= 35'(z);
        // hold the request until the edge where ready is seen
        do
        begin
            @(negedge clk);
            ok = req_ready;
            @(posedge clk);
        end while (!ok);
    endtask

    task automatic wait_drain();
        while (sb.pending_q.size() != 0) @(posedge clk);
    endtask

    function automatic longint any35();
        logic signed [34:0] v;
        v = 35'({$urandom, $urandom});
        return v;
    endfunction

    function automatic longint around(longint span);
        return $signed({$urandom, $urandom}) % (span + 1);
    endfunction

    task automatic send_random();
        longint x, y, z;
        int     pick;
        pick = $urandom_range(0, 99);
        if (pick < 35)
        begin
            x = any35(); y = any35(); z = any35();
        end
        else if (pick < 80)
        begin
            x = around(64'sd6500000000);
            y = around(64'sd6500000000);
            z = around(64'sd6400000000);
        end
        else if (pick < 90)
        begin
            x = around(1000); y = around(1000); z = around(1000);
        end
        else
        begin
            x = $urandom_range(0, 2) == 0 ? 0 : around(64'sd6500000000);
            y = $urandom_range(0, 2) == 0 ? 0 : around(64'sd6500000000);
            z = $urandom_range(0, 3) == 0 ? 0 : any35();
        end
        send(x, y, z);
    endtask

    initial
    begin
        longint maxv, minv;
        maxv = 64'sd17179869183;
        minv = -64'sd17179869184;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // poles, the origin, the axes, extremes and ordinary surface points
        send(0, 0, 64'sd6356752314);
        send(0, 0, -64'sd6356752314);
        send(0, 0, 0);
        send(0, 0, maxv);
        send(0, 0, minv);
        send(-64'sd6378137000, 0, 0);
        send(-1, 0, 5);
        send(64'sd6378137000, 0, 0);
        send(0, 64'sd6378137000, 0);
        send(0, -64'sd6378137000, 0);
        send(maxv, maxv, maxv);
        send(minv, minv, minv);
        send(maxv, minv, 0);
        send(64'sd10000000000, -64'sd10000000000, 64'sd10000000000);
        send(-64'sd10000000000, 64'sd10000000000, -64'sd10000000000);
        send(64'sd4510731000, 64'sd4510731000, 0);
        send(1000, 0, 0);
        send(1, 1, 1);
        send(-1, -1, -1);
        send(1, 0, 0);
        send(64'sd4198944000, 64'sd174747000, 64'sd4781475000);
        send(-64'sd2694044000, -64'sd4266368000, 64'sd3888137000);
        send(100, 0, -64'sd6356752000);

        // hold off until everything outstanding has drained
        req_valid <= 1'b0;
        wait_drain();

        send_idle_pct = 25; recv_idle_pct = 64;
        repeat (300) send_random();
        send_idle_pct = 64; recv_idle_pct = 25;
        repeat (300) send_random();
        send_idle_pct = 0; recv_idle_pct = 0;
        repeat (300) send_random();
        req_valid <= 1'b0;

        wait_drain();
        repeat (LATENCY + 50) @(posedge clk);
        if (sb.errors == 0)
            $display("PASS ecef_to_geodetic");
        else
            $display("FAIL ecef_to_geodetic");
        $finish;
    end

endmodule
